>>> rtl/nrmc_pkg.sv
`default_nettype none
package nrmc_pkg;

	// Default limit on the number of stored bytes of one field.
	localparam int MAX_FIELD_LEN_DEF = 16;

	// Width of the character position on the result side. The field limit is at most 32,
	// so the position counter never needs more than POS_EXT_W bits.
	localparam int POS_W     = 5;
	localparam int POS_EXT_W = 6;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;

	// Header and separator characters.
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_G      = 8'h47;
	localparam logic [7:0] CHR_P      = 8'h50;
	localparam logic [7:0] CHR_R      = 8'h52;
	localparam logic [7:0] CHR_M      = 8'h4D;
	localparam logic [7:0] CHR_C      = 8'h43;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;

	// Field identifiers as they appear on field_id.
	localparam logic [2:0] FID_TIME    = 3'd0;
	localparam logic [2:0] FID_LAT     = 3'd1;
	localparam logic [2:0] FID_LAT_DIR = 3'd2;
	localparam logic [2:0] FID_LON     = 3'd3;
	localparam logic [2:0] FID_LON_DIR = 3'd4;
	localparam logic [2:0] FID_SPEED   = 3'd5;
	localparam logic [2:0] FID_COURSE  = 3'd6;
	localparam logic [2:0] FID_DATE    = 3'd7;

	// One classified byte, handed from the front to the back.
	typedef struct packed {
		logic [2:0] field_id;
		logic [7:0] data;
		logic       is_dir;
		logic       last_field;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/nrmc_front.sv
`default_nettype none
module nrmc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	output logic               cmd_push,
	output nrmc_pkg::cmd_t     cmd
);

	typedef enum logic [17:0] {
		ST_HUNT     = 18'b000000000000000001,
		ST_HDR_G    = 18'b000000000000000010,
		ST_HDR_P    = 18'b000000000000000100,
		ST_HDR_R    = 18'b000000000000001000,
		ST_HDR_M    = 18'b000000000000010000,
		ST_HDR_C    = 18'b000000000000100000,
		ST_HDR_COM  = 18'b000000000001000000,
		ST_TIME     = 18'b000000000010000000,
		ST_STATUS   = 18'b000000000100000000,
		ST_LAT      = 18'b000000001000000000,
		ST_LAT_DIR  = 18'b000000010000000000,
		ST_SKIP1    = 18'b000000100000000000,
		ST_LON      = 18'b000001000000000000,
		ST_LON_DIR  = 18'b000010000000000000,
		ST_SKIP2    = 18'b000100000000000000,
		ST_SPEED    = 18'b001000000000000000,
		ST_COURSE   = 18'b010000000000000000,
		ST_DATE     = 18'b100000000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   enq;
	logic   is_comma;

	assign is_comma = (rx_byte == nrmc_pkg::CHR_COMMA);

	always_comb begin
		state_d        = state_q;
		enq            = 1'b0;
		cmd.field_id   = nrmc_pkg::FID_TIME;
		cmd.data       = rx_byte;
		cmd.is_dir     = 1'b0;
		cmd.last_field = 1'b0;
		unique case (state_q)
			ST_HUNT:    state_d = (rx_byte == nrmc_pkg::CHR_DOLLAR) ? ST_HDR_G : ST_HUNT;
			ST_HDR_G:   state_d = (rx_byte == nrmc_pkg::CHR_G) ? ST_HDR_P : ST_HUNT;
			ST_HDR_P:   state_d = (rx_byte == nrmc_pkg::CHR_P) ? ST_HDR_R : ST_HUNT;
			ST_HDR_R:   state_d = (rx_byte == nrmc_pkg::CHR_R) ? ST_HDR_M : ST_HUNT;
			ST_HDR_M:   state_d = (rx_byte == nrmc_pkg::CHR_M) ? ST_HDR_C : ST_HUNT;
			ST_HDR_C:   state_d = (rx_byte == nrmc_pkg::CHR_C) ? ST_HDR_COM : ST_HUNT;
			ST_HDR_COM: state_d = is_comma ? ST_TIME : ST_HUNT;
			ST_TIME: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_TIME;
				if (is_comma) state_d = ST_STATUS;
			end
			ST_STATUS: begin
				if (is_comma) state_d = ST_LAT;
			end
			ST_LAT: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_LAT;
				if (is_comma) state_d = ST_LAT_DIR;
			end
			ST_LAT_DIR: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_LAT_DIR;
				cmd.is_dir   = 1'b1;
				state_d      = ST_SKIP1;
			end
			ST_SKIP1:   state_d = ST_LON;
			ST_LON: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_LON;
				if (is_comma) state_d = ST_LON_DIR;
			end
			ST_LON_DIR: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_LON_DIR;
				cmd.is_dir   = 1'b1;
				state_d      = ST_SKIP2;
			end
			ST_SKIP2:   state_d = ST_SPEED;
			ST_SPEED: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_SPEED;
				if (is_comma) state_d = ST_COURSE;
			end
			ST_COURSE: begin
				enq          = 1'b1;
				cmd.field_id = nrmc_pkg::FID_COURSE;
				if (is_comma) state_d = ST_DATE;
			end
			ST_DATE: begin
				enq            = 1'b1;
				cmd.field_id   = nrmc_pkg::FID_DATE;
				cmd.last_field = 1'b1;
				if (is_comma) state_d = ST_HUNT;
			end
			default:    state_d = ST_HUNT;
		endcase
	end

	assign cmd_push = accept & enq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/nrmc_queue.sv
`default_nettype none
module nrmc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire nrmc_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           rd_en,
	output nrmc_pkg::cmd_t      rd_cmd,
	output logic                empty
);

	localparam int PtrW = (nrmc_pkg::QUEUE_DEPTH > 1) ? $clog2(nrmc_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(nrmc_pkg::QUEUE_DEPTH + 1);

	nrmc_pkg::cmd_t entries_q [nrmc_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full   = (count_q == CntW'(nrmc_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en & ~full;
	assign do_rd  = rd_en & ~empty;
	assign rd_cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
			if (do_rd) rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
			if (do_wr && !do_rd) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/nrmc_back.sv
`default_nettype none
module nrmc_back #(
	parameter int MAX_FIELD_LEN = nrmc_pkg::MAX_FIELD_LEN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	input  wire nrmc_pkg::cmd_t         q_cmd,
	output logic                        q_pop,
	input  wire logic                   pop,
	output logic                        empty,
	output logic [2:0]                  field_id,
	output logic [nrmc_pkg::POS_W-1:0]  char_pos,
	output logic [7:0]                  char_data,
	output logic                        field_end,
	output logic                        field_overflow,
	output logic                        sentence_done
);

	localparam int PosW = $clog2(MAX_FIELD_LEN + 1);

	logic [PosW-1:0]               pos_q;
	logic                          ovf_q;
	logic                          out_valid_q;
	logic                          take;
	logic                          is_comma;
	logic                          room;
	logic                          emit;
	logic [nrmc_pkg::POS_EXT_W-1:0] pos_ext;
	logic [nrmc_pkg::POS_W-1:0]     pos_sat;

	logic [2:0]                 field_id_q;
	logic [nrmc_pkg::POS_W-1:0] char_pos_q;
	logic [7:0]                 char_data_q;
	logic                       field_end_q;
	logic                       field_overflow_q;
	logic                       sentence_done_q;

	assign take     = ~q_empty & (~out_valid_q | pop);
	assign q_pop    = take;
	assign is_comma = (q_cmd.data == nrmc_pkg::CHR_COMMA);
	assign room     = (pos_q < PosW'(MAX_FIELD_LEN));
	assign emit     = q_cmd.is_dir | is_comma | room;
	assign pos_ext  = nrmc_pkg::POS_EXT_W'(pos_q);
	assign pos_sat  = (pos_ext > nrmc_pkg::POS_EXT_W'(31)) ? nrmc_pkg::POS_W'(31)
	                                                       : pos_ext[nrmc_pkg::POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
			if (!q_cmd.is_dir) begin
				if (is_comma) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end else if (room) begin
					pos_q <= PosW'(pos_q + 1'b1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			field_id_q  <= q_cmd.field_id;
			char_data_q <= q_cmd.data;
			if (q_cmd.is_dir) begin
				char_pos_q       <= '0;
				field_end_q      <= 1'b1;
				field_overflow_q <= 1'b0;
				sentence_done_q  <= 1'b0;
			end else begin
				char_pos_q       <= pos_sat;
				field_end_q      <= is_comma;
				field_overflow_q <= is_comma & ovf_q;
				sentence_done_q  <= is_comma & q_cmd.last_field;
			end
		end
	end

	assign empty          = ~out_valid_q;
	assign field_id       = field_id_q;
	assign char_pos       = char_pos_q;
	assign char_data      = char_data_q;
	assign field_end      = field_end_q;
	assign field_overflow = field_overflow_q;
	assign sentence_done  = sentence_done_q;

endmodule
`default_nettype wire

>>> rtl/nmea_rmc_field_extractor.sv
`default_nettype none
// Extracts the fields of $GPRMC sentences from a byte stream, one received character per item.
// After the header "$GPRMC," it delivers time, latitude, latitude direction, longitude,
// longitude direction, speed, course and date, each stored byte as one result item tagged
// with its field and position; a field's terminating comma is delivered too, with field_end
// set, and the comma that ends the date also carries sentence_done. Header bytes, the status
// field and the byte after each direction produce no result. Bytes past MAX_FIELD_LEN in a
// field are dropped and flagged on that field's comma. The block takes one byte every clock
// cycle, sustained, while full is low. The result of a byte reaches the result ports through
// the queue entry and then the output register: the front updates the sentence phase and
// writes a classified item into a two-entry queue, and the back, whenever its output register
// is free or being popped, updates the field position and loads the output register. full
// rises only when that queue is full because results are not popped.
module nmea_rmc_field_extractor #(
	parameter int MAX_FIELD_LEN = nrmc_pkg::MAX_FIELD_LEN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             rx_byte,
	input  wire logic                   pop,
	output logic                        empty,
	output logic [2:0]                  field_id,
	output logic [nrmc_pkg::POS_W-1:0]  char_pos,
	output logic [7:0]                  char_data,
	output logic                        field_end,
	output logic                        field_overflow,
	output logic                        sentence_done
);

	// The front sees a byte only when the queue has room, so every accepted item is
	// classified at once and, if it yields a result, written to the queue.
	logic           accept;
	logic           cmd_push;
	nrmc_pkg::cmd_t cmd;
	nrmc_pkg::cmd_t q_cmd;
	logic           q_empty;
	logic           q_pop;

	assign accept = push & ~full;

	nrmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	nrmc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.full   (full),
		.rd_en  (q_pop),
		.rd_cmd (q_cmd),
		.empty  (q_empty)
	);

	// The back keeps the position and overflow mark of the current field and holds the
	// result register that the consumer pops from.
	nrmc_back #(
		.MAX_FIELD_LEN (MAX_FIELD_LEN)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.field_id       (field_id),
		.char_pos       (char_pos),
		.char_data      (char_data),
		.field_end      (field_end),
		.field_overflow (field_overflow),
		.sentence_done  (sentence_done)
	);

	// The end of a sentence is only ever the comma that closes the date field.
	a_done_on_date_comma: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sentence_done) |->
		(field_end && field_id == nrmc_pkg::FID_DATE && char_data == nrmc_pkg::CHR_COMMA))
		else $error("sentence_done on a result that is not the date terminator");

	// An overflow is reported only on a terminating comma, which then sits past the limit.
	a_overflow_on_comma: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && field_overflow) |->
		(field_end && char_data == nrmc_pkg::CHR_COMMA
		 && 32'(char_pos) == ((MAX_FIELD_LEN > 31) ? 31 : MAX_FIELD_LEN)))
		else $error("field_overflow on a result that is not a saturated terminator");

	// A data byte that does not end its field always lies within the length limit.
	a_data_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !field_end) |-> (32'(char_pos) < MAX_FIELD_LEN))
		else $error("data byte delivered beyond the field length limit");

	// Direction fields are one byte long and always end at once.
	a_dir_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (field_id == nrmc_pkg::FID_LAT_DIR || field_id == nrmc_pkg::FID_LON_DIR))
		|-> (field_end && char_pos == '0 && !field_overflow))
		else $error("direction result that is not a single closed byte");

endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The block runs with its default field limit, so the predictor uses the same value.
	localparam int FIELD_LIMIT = nrmc_pkg::MAX_FIELD_LEN_DEF;

	// Stimulus stops once about this many input items have been taken by the block.
	localparam int INPUT_ITEMS_WANTED = 1300;

	// Sentence phases as the predictor tracks them. The first seven hunt for the header
	// characters in turn; the rest follow the fixed field order of the sentence.
	typedef enum int {
		HUNT_DOLLAR, HUNT_G, HUNT_P, HUNT_R, HUNT_M, HUNT_C, HUNT_COMMA,
		IN_TIME, IN_STATUS, IN_LAT, IN_LAT_DIR, IN_SKIP1,
		IN_LON, IN_LON_DIR, IN_SKIP2, IN_SPEED, IN_COURSE, IN_DATE
	} rmc_phase_t;

	// One field byte as it leaves the block.
	typedef struct {
		logic [2:0]                 fid;
		logic [nrmc_pkg::POS_W-1:0] pos;
		logic [7:0]                 data;
		logic                       fld_end;
		logic                       ovf;
		logic                       done;
	} field_byte_t;

	// Follows the sentence byte by byte and keeps the field bytes that the block still owes.
	class rmc_field_predictor_t;
		rmc_phase_t  phase;
		int unsigned field_pos;
		bit          bytes_dropped;
		logic [7:0]  header_seq [7];
		field_byte_t owed_bytes [$];
		int unsigned items_noted;
		int unsigned errors;

		function new();
			header_seq = '{nrmc_pkg::CHR_DOLLAR, nrmc_pkg::CHR_G, nrmc_pkg::CHR_P,
				nrmc_pkg::CHR_R, nrmc_pkg::CHR_M, nrmc_pkg::CHR_C, nrmc_pkg::CHR_COMMA};
			phase = HUNT_DOLLAR;
			field_pos = 0;
			bytes_dropped = 1'b0;
			items_noted = 0;
			errors = 0;
		endfunction

		function void owe(logic [2:0] fid, int unsigned pos, logic [7:0] data,
				bit fld_end, bit ovf, bit done);
			field_byte_t fb;
			fb.fid = fid;
			fb.pos = (pos > 31) ? 5'd31 : pos[nrmc_pkg::POS_W-1:0];
			fb.data = data;
			fb.fld_end = fld_end;
			fb.ovf = ovf;
			fb.done = done;
			owed_bytes.push_back(fb);
		endfunction

		// A byte of a stored field: the comma closes it, anything past the limit is dropped.
		function void capture(logic [2:0] fid, logic [7:0] b, rmc_phase_t next_phase, bit done);
			if (b == nrmc_pkg::CHR_COMMA) begin
				owe(fid, field_pos, b, 1'b1, bytes_dropped, done);
				field_pos = 0;
				bytes_dropped = 1'b0;
				phase = next_phase;
			end else if (field_pos < FIELD_LIMIT) begin
				owe(fid, field_pos, b, 1'b0, 1'b0, 1'b0);
				field_pos++;
			end else begin
				bytes_dropped = 1'b1;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			items_noted++;
			if (phase < IN_TIME) begin
				// Any mismatch in the header, a second dollar included, starts the hunt again.
				if (b == header_seq[int'(phase)]) begin
					phase = rmc_phase_t'(int'(phase) + 1);
					field_pos = 0;
					bytes_dropped = 1'b0;
				end else begin
					phase = HUNT_DOLLAR;
				end
				return;
			end
			case (phase)
				IN_TIME:   capture(nrmc_pkg::FID_TIME, b, IN_STATUS, 1'b0);
				IN_STATUS: begin
					if (b == nrmc_pkg::CHR_COMMA) begin
						phase = IN_LAT;
						field_pos = 0;
						bytes_dropped = 1'b0;
					end
				end
				IN_LAT:     capture(nrmc_pkg::FID_LAT, b, IN_LAT_DIR, 1'b0);
				IN_LAT_DIR: begin
					owe(nrmc_pkg::FID_LAT_DIR, 0, b, 1'b1, 1'b0, 1'b0);
					phase = IN_SKIP1;
				end
				IN_SKIP1: begin
					phase = IN_LON;
					field_pos = 0;
					bytes_dropped = 1'b0;
				end
				IN_LON:     capture(nrmc_pkg::FID_LON, b, IN_LON_DIR, 1'b0);
				IN_LON_DIR: begin
					owe(nrmc_pkg::FID_LON_DIR, 0, b, 1'b1, 1'b0, 1'b0);
					phase = IN_SKIP2;
				end
				IN_SKIP2: begin
					phase = IN_SPEED;
					field_pos = 0;
					bytes_dropped = 1'b0;
				end
				IN_SPEED:  capture(nrmc_pkg::FID_SPEED, b, IN_COURSE, 1'b0);
				IN_COURSE: capture(nrmc_pkg::FID_COURSE, b, IN_DATE, 1'b0);
				default:   capture(nrmc_pkg::FID_DATE, b, HUNT_DOLLAR, 1'b1);
			endcase
		endfunction

		// Four-state compare, so that an unknown value on a port counts as a mismatch.
		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_byte(field_byte_t got);
			field_byte_t want;
			if (owed_bytes.size() == 0) begin
				$error("field byte with nothing owed: field_id %0d char_pos %0d char_data %0d",
					got.fid, got.pos, got.data);
				errors++;
				return;
			end
			want = owed_bytes.pop_front();
			compare("field_id", want.fid, got.fid);
			compare("char_pos", want.pos, got.pos);
			compare("char_data", want.data, got.data);
			compare("field_end", want.fld_end, got.fld_end);
			compare("field_overflow", want.ovf, got.ovf);
			compare("sentence_done", want.done, got.done);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [7:0]                 rx_byte;
	logic                       pop;
	logic                       empty;
	logic [2:0]                 field_id;
	logic [nrmc_pkg::POS_W-1:0] char_pos;
	logic [7:0]                 char_data;
	logic                       field_end;
	logic                       field_overflow;
	logic                       sentence_done;

	rmc_field_predictor_t tracker = new();

	// Counters of the calm stretches, in which a side takes or gives every item at once.
	int send_calm = 0;
	int pop_calm = 0;

	nmea_rmc_field_extractor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.pop            (pop),
		.empty          (empty),
		.field_id       (field_id),
		.char_pos       (char_pos),
		.char_data      (char_data),
		.field_end      (field_end),
		.field_overflow (field_overflow),
		.sentence_done  (sentence_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Draws the number of idle cycles before the next item. Now and then a calm stretch
	// starts, so that back-to-back traffic is seen as well as gaps of every length.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// Offers one byte and waits until the block takes it. push is left high on return, so
	// that a following item with no gap keeps it high without a glitch in the same step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		tracker.note_byte(b);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Field content: mostly digits and points, as in real sentences, and now and then any
	// byte but the comma, so that every bit of the input is exercised.
	function automatic logic [7:0] pick_data();
		logic [7:0] b;
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 9) == 0)
				return 8'h2E;
			return 8'h30 + 8'($urandom_range(0, 9));
		end
		do b = 8'($urandom_range(0, 255)); while (b == nrmc_pkg::CHR_COMMA);
		return b;
	endfunction

	// A direction byte is normally one of two letters, but the block takes anything there.
	function automatic logic [7:0] pick_dir(input logic [7:0] a, input logic [7:0] b);
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return $urandom_range(0, 1) ? a : b;
	endfunction

	// The byte after a direction is skipped whatever it is; normally it is a comma.
	function automatic logic [7:0] pick_skip();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return nrmc_pkg::CHR_COMMA;
	endfunction

	// A stored field and its comma. About one field in eight runs close to or past the limit.
	task automatic send_field();
		int len;
		if ($urandom_range(0, 7) == 0)
			len = $urandom_range(FIELD_LIMIT - 2, FIELD_LIMIT + 6);
		else
			len = $urandom_range(0, 10);
		repeat (len) send_byte(pick_data());
		send_byte(nrmc_pkg::CHR_COMMA);
	endtask

	task automatic send_sentence();
		send_text("$GPRMC,");
		send_field();
		// The status field is skipped up to and including its comma.
		repeat ($urandom_range(0, 2)) send_byte(pick_data());
		send_byte(nrmc_pkg::CHR_COMMA);
		send_field();
		send_byte(pick_dir(8'h4E, 8'h53));
		send_byte(pick_skip());
		send_field();
		send_byte(pick_dir(8'h45, 8'h57));
		send_byte(pick_skip());
		send_field();
		send_field();
		send_field();
	endtask

	// A header cut short by a wrong byte, which may itself be a dollar.
	task automatic send_broken_header();
		string hdr;
		int k;
		int i;
		logic [7:0] b;
		hdr = "$GPRMC,";
		k = $urandom_range(1, 6);
		for (i = 0; i < k; i++)
			send_byte(hdr[i]);
		if ($urandom_range(0, 1))
			b = nrmc_pkg::CHR_DOLLAR;
		else
			b = 8'($urandom_range(0, 255));
		send_byte(b);
	endtask

	// Loose bytes between sentences, rich in header characters.
	task automatic send_noise();
		logic [7:0] pool [7];
		pool = '{nrmc_pkg::CHR_DOLLAR, nrmc_pkg::CHR_G, nrmc_pkg::CHR_P, nrmc_pkg::CHR_R,
			nrmc_pkg::CHR_M, nrmc_pkg::CHR_C, nrmc_pkg::CHR_COMMA};
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 1))
				send_byte(pool[$urandom_range(0, 6)]);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// The result side takes a field byte at an edge where pop is high and empty is low.
	// Values are read straight after the edge, before the block's registers move on, so
	// they are the ones that the handshake accepted.
	initial begin : result_drain
		field_byte_t got;
		int hold;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		hold = draw_gap(pop_calm);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.fid = field_id;
				got.pos = char_pos;
				got.data = char_data;
				got.fld_end = field_end;
				got.ovf = field_overflow;
				got.done = sentence_done;
				tracker.check_byte(got);
				hold = draw_gap(pop_calm);
			end else if (hold > 0) begin
				hold--;
			end
			pop <= (hold == 0);
		end
	end

	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sentence. A doubled dollar breaks the header and is dropped. All stored
		// fields are empty except latitude, which carries a dollar as plain data. The
		// latitude direction is a comma, the longitude direction and its skipped byte are
		// the extreme byte values, and the status field carries one letter.
		send_text("$$");
		send_text("$GPRMC,");
		send_text(",A,$,,X,");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_text(",,,");

		// Random part: mostly well-formed sentences with random content, the rest noise
		// and broken headers.
		while (tracker.items_noted < INPUT_ITEMS_WANTED) begin
			case ($urandom_range(0, 7))
				0:       send_noise();
				1:       send_broken_header();
				default: send_sentence();
			endcase
		end
		push <= 1'b0;

		// Let the owed field bytes drain, then give the two-stage pipeline time to show any
		// byte that it should not produce.
		for (n = 0; n < 5000 && tracker.owed_bytes.size() != 0; n++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.owed_bytes.size() != 0) begin
			$error("%0d field bytes never delivered", tracker.owed_bytes.size());
			tracker.errors++;
		end

		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin : watchdog
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
